// ===== hdl/stfop_pkg.sv =====
// Shared types and constants for the serial transmitter with odd parity.
// No dependencies; imported by every module of the block.
package stfop_pkg;

    localparam int FIFO_DEPTH = 1024;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int DATA_BITS  = 8;
    localparam int CNT_W      = 4;

    // one queued request, already classified by the front end
    typedef struct packed {
        logic       is_tick;
        logic [7:0] data_byte;
    } t_cmd;

    typedef struct packed {
        logic line_level;
        logic accepted;
        logic busy_res;
        logic byte_done;
    } t_res;

    // front end -> back end request channel
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_chan;

endpackage

// ===== hdl/serial_tx_fifo_odd_parity_core.sv =====
// Serial transmitter (8 data bits, odd parity, 1 stop) fed by a byte ring buffer.
// Top level; instantiates stfop_front and stfop_back, uses stfop_pkg.
//
// Input channel: push/full. Each request carries i_mode (0 = queue i_data_byte,
// 1 = one bit-time tick). A request is taken at an edge with push high and
// full low. Result channel: empty/pop. For every request exactly one result
// (line level after the request, accepted, busy, byte done) comes out, in
// order; it is taken at an edge with pop high and empty low.
// A tick frame sends start 0, eight data bits LSB first, odd parity, stop 1;
// the ring buffer holds FIFO_DEPTH-1 bytes, extra pushes are dropped.
// A request taken by the front end waits in the request queue; the execute
// stage writes its result into the result queue at the edge on which it
// executes, which cannot happen while the result queue is full. Throughput is
// one request per cycle while the result queue has room, set by the execute
// step and the one buffer write plus one buffer read it needs per cycle.
// Reset (synchronous, active low) empties both queues and the ring buffer
// pointers, parks the frame sequencer idle and drives the line high; buffer
// contents are not cleared. When the receiver stops popping, the two-entry
// result queue fills, execution stops, and after the two-entry request queue
// fills, full rises; nothing is lost.
module serial_tx_fifo_odd_parity_core import stfop_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic       i_mode,
    input  logic [7:0] i_data_byte,
    output logic       empty,
    input  logic       pop,
    output logic       o_line_level,
    output logic       o_accepted,
    output logic       o_busy_res,
    output logic       o_byte_done
);

    t_cmd_chan w_chan;
    logic      w_take;
    t_res      w_res;

    stfop_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_mode      (i_mode),
        .i_data_byte (i_data_byte),
        .o_chan      (w_chan),
        .i_take      (w_take)
    );

    stfop_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_chan  (w_chan),
        .o_take  (w_take),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (w_res)
    );

    assign o_line_level = w_res.line_level;
    assign o_accepted   = w_res.accepted;
    assign o_busy_res   = w_res.busy_res;
    assign o_byte_done  = w_res.byte_done;

endmodule

// ===== hdl/stfop_front.sv =====
// Front end: takes requests from the input port, classifies them as push or
// tick and holds them in a two-entry queue for the back end. Uses stfop_pkg.
module stfop_front import stfop_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic       i_mode,
    input  logic [7:0] i_data_byte,
    output t_cmd_chan  o_chan,
    input  logic       i_take
);

    t_cmd       r_q [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_cnt;
    logic       w_in, w_out;

    assign o_full = (r_cnt == 2'd2);
    assign w_in   = i_push && !o_full;
    assign w_out  = i_take && (r_cnt != 2'd0);

    assign o_chan.valid = (r_cnt != 2'd0);
    assign o_chan.cmd   = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_in) begin
            r_q[r_wr_ptr].is_tick   <= i_mode;
            r_q[r_wr_ptr].data_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_in)  r_wr_ptr <= ~r_wr_ptr;
            if (w_out) r_rd_ptr <= ~r_rd_ptr;
            r_cnt <= r_cnt + {1'b0, w_in} - {1'b0, w_out};
        end
    end

endmodule

// ===== hdl/stfop_back.sv =====
// Back end: byte ring buffer, frame sequencer and two-entry result queue.
// Executes one request per cycle while the result queue has room. Uses stfop_pkg.
module stfop_back import stfop_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd_chan i_chan,
    output logic      o_take,
    output logic      o_empty,
    input  logic      i_pop,
    output t_res      o_res
);

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_START  = 5'b00010,
        PH_DATA   = 5'b00100,
        PH_PARITY = 5'b01000,
        PH_STOP   = 5'b10000
    } t_phase;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        ptr_next = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [7:0]       mem [FIFO_DEPTH];
    logic [7:0]       r_rd_data;

    logic [PTR_W-1:0] r_head, n_head, r_tail, n_tail;
    logic [7:0]       r_shift, n_shift;
    logic [CNT_W-1:0] r_bits, n_bits;
    t_phase           r_phase, n_phase;
    logic             r_par, n_par;
    logic             r_line, n_line;
    logic             r_load, n_load;

    logic             w_fire, w_wr, w_acc, w_done;
    logic [PTR_W-1:0] w_nt;
    t_cmd             w_cmd;

    t_res             r_oq [2];
    logic             r_owr, r_ord;
    logic [1:0]       r_ocnt;
    logic             w_pop;

    assign w_cmd   = i_chan.cmd;
    assign w_fire  = i_chan.valid && (r_ocnt != 2'd2);
    assign o_take  = w_fire;
    assign w_nt    = ptr_next(r_tail);

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_shift = r_shift;
        n_bits  = r_bits;
        n_phase = r_phase;
        n_par   = r_par;
        n_line  = r_line;
        n_load  = 1'b0;
        w_wr    = 1'b0;
        w_acc   = 1'b0;
        w_done  = 1'b0;
        // head byte loaded in the cycle after a stop-bit re-arm
        if (r_load) begin
            n_shift = r_rd_data;
            n_par   = ~(^r_rd_data);
        end
        if (w_fire) begin
            if (!w_cmd.is_tick) begin
                if (w_nt != r_head) begin
                    w_wr   = 1'b1;
                    w_acc  = 1'b1;
                    n_tail = w_nt;
                    if (r_phase == PH_IDLE) begin
                        // buffer was empty: the pushed byte is the head
                        n_shift = w_cmd.data_byte;
                        n_par   = ~(^w_cmd.data_byte);
                        n_bits  = '0;
                        n_phase = PH_START;
                    end
                end
            end else begin
                unique case (r_phase)
                    PH_IDLE: ;
                    PH_START: begin
                        n_line  = 1'b0;
                        n_phase = PH_DATA;
                    end
                    PH_DATA: begin
                        n_line  = r_shift[0];
                        n_shift = {1'b0, r_shift[7:1]};
                        n_bits  = r_bits + 1'b1;
                        if (n_bits >= CNT_W'(DATA_BITS)) n_phase = PH_PARITY;
                    end
                    PH_PARITY: begin
                        n_line  = r_par;
                        n_phase = PH_STOP;
                    end
                    PH_STOP: begin
                        n_line = 1'b1;
                        w_done = 1'b1;
                        n_head = ptr_next(r_head);
                        if (n_head != r_tail) begin
                            n_load  = 1'b1;
                            n_bits  = '0;
                            n_phase = PH_START;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // ring buffer: write at tail, read at the next head
    always_ff @(posedge i_clk) begin
        if (w_wr) mem[r_tail] <= w_cmd.data_byte;
        r_rd_data <= mem[n_head];
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_par   <= n_par;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_bits  <= '0;
            r_phase <= PH_IDLE;
            r_line  <= 1'b1;
            r_load  <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_bits  <= n_bits;
            r_phase <= n_phase;
            r_line  <= n_line;
            r_load  <= n_load;
        end
    end

    // result queue
    assign o_empty = (r_ocnt == 2'd0);
    assign w_pop   = i_pop && !o_empty;
    assign o_res   = r_oq[r_ord];

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_oq[r_owr].line_level <= n_line;
            r_oq[r_owr].accepted   <= w_acc;
            r_oq[r_owr].busy_res   <= (n_phase != PH_IDLE);
            r_oq[r_owr].byte_done  <= w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= 1'b0;
            r_ord  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (w_fire) r_owr <= ~r_owr;
            if (w_pop)  r_ord <= ~r_ord;
            r_ocnt <= r_ocnt + {1'b0, w_fire} - {1'b0, w_pop};
        end
    end

endmodule
